// ----- hdl/bfdh_pkg.sv -----
`default_nettype none
package bfdh_pkg;

    localparam int WORD_COUNT = 1024;
    localparam int WORD_AW    = $clog2(WORD_COUNT);
    localparam int MAX_PROBES = 16;
    localparam int BITS_W     = 17;
    localparam int PROBES_W   = 5;
    localparam int PROBE_IW   = $clog2(MAX_PROBES);
    localparam int HASH_W     = 64;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_RADIX  = 4;
    localparam int DIV_STEPS  = HASH_W / DIV_RADIX;
    localparam int DIV_CW     = $clog2(DIV_STEPS);

    localparam logic [BITS_W-1:0]   BIT_LIMIT   = BITS_W'(WORD_COUNT * 64);
    localparam logic [BITS_W-1:0]   BITS_RESET  = BITS_W'(65536);
    localparam logic [PROBES_W-1:0] PROBE_LIMIT = PROBES_W'(MAX_PROBES);
    localparam logic [PROBES_W-1:0] PROBE_RESET = PROBES_W'(7);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_COUNT   = 4'd0,
        REG_PROBE_COUNT = 4'd1
    } t_reg_idx;

    typedef enum logic {
        ACT_ADD   = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    // One classified word handed from the front to the back.
    typedef struct packed {
        t_action               action;
        logic [HASH_W-1:0]     hash_first;
        logic [HASH_W-1:0]     hash_second;
        logic [BITS_W-1:0]     bits;
        logic [PROBES_W-1:0]   probes;
    } t_cmd;

endpackage
`default_nettype wire

// ----- hdl/bloom_filter_double_hash_top.sv -----
// Channel   Handshake                  Payload
// input     i_push / o_full            i_action, i_hash_first, i_hash_second
// result    o_empty / i_pop            o_maybe_present
// config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each probe runs the remainder unit (four bits per cycle over the 64-bit
// running hash), then one memory read and one update.
// An add ends after its last probe; a query then posts its result from a
// result state. A query stops after the probe that finds a clear bit, and a
// full result queue holds it in that result state.
// After reset the 1024-word store is cleared, one word a cycle, while o_full
// stays high; configuration writes are taken throughout.
// A two-word command queue and a two-word result queue let input and output
// stall independently of the probe engine.
`default_nettype none
module bloom_filter_double_hash_top
    import bfdh_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire logic                  i_action,
    input  wire logic [HASH_W-1:0]     i_hash_first,
    input  wire logic [HASH_W-1:0]     i_hash_second,
    output logic                       o_empty,
    input  wire logic                  i_pop,
    output logic                       o_maybe_present,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    logic  link_valid;
    logic  link_take;
    logic  link_clearing;

    bfdh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_action      (i_action),
        .i_hash_first  (i_hash_first),
        .i_hash_second (i_hash_second),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_take        (link_take),
        .i_clearing    (link_clearing),
        .o_valid       (link_valid),
        .o_cmd         (cmd)
    );

    bfdh_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (link_valid),
        .i_cmd           (cmd),
        .o_take          (link_take),
        .o_clearing      (link_clearing),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_maybe_present (o_maybe_present)
    );

endmodule
`default_nettype wire

// ----- hdl/bfdh_front.sv -----
`default_nettype none
module bfdh_front
    import bfdh_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire logic                  i_action,
    input  wire logic [HASH_W-1:0]     i_hash_first,
    input  wire logic [HASH_W-1:0]     i_hash_second,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_take,
    input  wire logic                  i_clearing,
    output logic                       o_valid,
    output t_cmd                       o_cmd
);

    logic [BITS_W-1:0]   r_bit_count;
    logic [PROBES_W-1:0] r_probe_count;
    t_cmd                r_q [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;
    logic [BITS_W-1:0]   eff_bits;
    logic [PROBES_W-1:0] eff_probes;
    logic                accept;
    t_cmd                new_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count   <= BITS_RESET;
            r_probe_count <= PROBE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BIT_COUNT:   r_bit_count   <= i_cfg_data[BITS_W-1:0];
                REG_PROBE_COUNT: r_probe_count <= i_cfg_data[PROBES_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero and out-of-range settings are folded into legal values here.
    always_comb begin
        eff_bits = r_bit_count;
        if (r_bit_count == '0) begin
            eff_bits = BITS_W'(1);
        end else if (r_bit_count > BIT_LIMIT) begin
            eff_bits = BIT_LIMIT;
        end
        eff_probes = r_probe_count;
        if (r_probe_count == '0) begin
            eff_probes = PROBES_W'(1);
        end else if (r_probe_count > PROBE_LIMIT) begin
            eff_probes = PROBE_LIMIT;
        end
    end

    always_comb begin
        new_cmd.action      = t_action'(i_action);
        new_cmd.hash_first  = i_hash_first;
        new_cmd.hash_second = i_hash_second;
        new_cmd.bits        = eff_bits;
        new_cmd.probes      = eff_probes;
    end

    assign o_full  = (r_cnt == 2'd2) || i_clearing;
    assign accept  = i_push && !o_full;
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= new_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_wp <= ~r_wp;
            end
            if (i_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(accept) - 2'(i_take);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("command queue count out of range");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> o_valid)
        else $error("command taken from empty queue");

    a_head_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cmd.bits != '0 && o_cmd.bits <= BIT_LIMIT
                     && o_cmd.probes != '0 && o_cmd.probes <= PROBE_LIMIT))
        else $error("queued command carries illegal sizes");

endmodule
`default_nettype wire

// ----- hdl/bfdh_back.sv -----
`default_nettype none
module bfdh_back
    import bfdh_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_cmd  i_cmd,
    output logic       o_take,
    output logic       o_clearing,
    output logic       o_empty,
    input  wire logic  i_pop,
    output logic       o_maybe_present
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_DIV    = 6'b000100,
        S_READ   = 6'b001000,
        S_UPD    = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state                r_state;
    logic [WORD_AW-1:0]    r_clr_addr;
    t_action               r_act;
    logic [HASH_W-1:0]     r_run;
    logic [HASH_W-1:0]     r_step;
    logic [HASH_W-1:0]     r_dividend;
    logic [BITS_W-1:0]     r_m;
    logic [PROBES_W-1:0]   r_k;
    logic [PROBE_IW-1:0]   r_probe;
    logic [DIV_CW-1:0]     r_div_cnt;
    logic [BITS_W-1:0]     r_rem;
    logic                  r_present;
    logic [63:0]           r_mem [WORD_COUNT];
    logic [63:0]           r_rd_data;
    logic                  r_res [2];
    logic                  r_res_wp;
    logic                  r_res_rp;
    logic [1:0]            r_res_cnt;

    logic [BITS_W-1:0]     n_rem;
    logic [HASH_W-1:0]     n_run;
    logic                  probe_bit;
    logic                  last_probe;
    logic                  mem_we;
    logic [WORD_AW-1:0]    mem_waddr;
    logic [63:0]           mem_wdata;
    logic [WORD_AW-1:0]    word_addr;
    logic                  res_push;
    logic                  res_pop;

    assign o_take     = (r_state == S_IDLE) && i_valid;
    assign o_clearing = (r_state == S_CLEAR);
    assign word_addr  = r_rem[6 +: WORD_AW];
    assign probe_bit  = r_rd_data[r_rem[5:0]];
    assign last_probe = ({1'b0, r_probe} + PROBES_W'(1)) == r_k;
    assign n_run      = r_run + r_step;

    // Four restoring-division steps per cycle; the remainder stays below m.
    always_comb begin
        logic [BITS_W-1:0] t;
        t     = '0;
        n_rem = r_rem;
        for (int j = 0; j < DIV_RADIX; j++) begin
            t = {n_rem[BITS_W-2:0], r_dividend[HASH_W-1-j]};
            if (t >= r_m) begin
                t = t - r_m;
            end
            n_rem = t;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = word_addr;
        mem_wdata = r_rd_data | (64'd1 << r_rem[5:0]);
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (r_state == S_UPD && r_act == ACT_ADD) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[word_addr];
        end
    end

    assign res_push = (r_state == S_RESULT) && (r_res_cnt != 2'd2);
    assign res_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_probe    <= '0;
            r_div_cnt  <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + WORD_AW'(1);
                    if (r_clr_addr == WORD_AW'(WORD_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_state   <= S_DIV;
                        r_probe   <= '0;
                        r_div_cnt <= '0;
                    end
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + DIV_CW'(1);
                    if (r_div_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_act == ACT_QUERY && !probe_bit) begin
                        r_state <= S_RESULT;
                    end else if (last_probe) begin
                        r_state <= (r_act == ACT_QUERY) ? S_RESULT : S_IDLE;
                    end else begin
                        r_state   <= S_DIV;
                        r_probe   <= r_probe + PROBE_IW'(1);
                        r_div_cnt <= '0;
                    end
                end
                S_RESULT: begin
                    if (res_push) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // Datapath registers follow the state machine without reset.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_act      <= i_cmd.action;
                r_run      <= i_cmd.hash_first;
                r_step     <= i_cmd.hash_second;
                r_dividend <= i_cmd.hash_first;
                r_m        <= i_cmd.bits;
                r_k        <= i_cmd.probes;
                r_rem      <= '0;
                r_present  <= 1'b1;
            end
            S_DIV: begin
                r_rem      <= n_rem;
                r_dividend <= r_dividend << DIV_RADIX;
            end
            S_UPD: begin
                if (r_act == ACT_QUERY && !probe_bit) begin
                    r_present <= 1'b0;
                end
                // The next probe's step grows by its own probe number.
                r_run      <= n_run;
                r_dividend <= n_run;
                r_step     <= r_step + HASH_W'({1'b0, r_probe} + PROBES_W'(1));
                r_rem      <= '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res[r_res_wp] <= r_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wp  <= 1'b0;
            r_res_rp  <= 1'b0;
            r_res_cnt <= 2'd0;
        end else begin
            if (res_push) begin
                r_res_wp <= ~r_res_wp;
            end
            if (res_pop) begin
                r_res_rp <= ~r_res_rp;
            end
            r_res_cnt <= r_res_cnt + 2'(res_push) - 2'(res_pop);
        end
    end

    assign o_empty         = (r_res_cnt == 2'd0);
    assign o_maybe_present = r_res[r_res_rp];

    a_result_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RESULT |-> r_act == ACT_QUERY)
        else $error("result raised for an add");

    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_take)
        else $error("command taken during store clear");

    a_rem_below_m: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_UPD) |-> r_rem < r_m)
        else $error("probe position not below bit count");

    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_cnt <= 2'd2)
        else $error("result queue count out of range");

endmodule
`default_nettype wire
